// ----- rtl/tcw_pkg.sv -----
// tcw_pkg: shared constants, command and state types of the text console writer.
// Used by tcw_front, tcw_back and text_console_writer; depends on nothing.
package tcw_pkg;

	// screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam int MOVED   = CELLS - COLUMNS;
	localparam int ADDR_W  = $clog2(CELLS);

	// port widths fixed by the field definitions
	localparam int KIND_W     = 2;
	localparam int CHAR_W     = 8;
	localparam int COLOR_W    = 8;
	localparam int NIBBLE_W   = 4;
	localparam int CELL_IDX_W = 11;
	localparam int ROW_W      = 5;
	localparam int COL_W      = 7;
	localparam int CFG_IDX_W  = 4;

	// byte and color codes
	localparam logic [CHAR_W-1:0]   NEWLINE_BYTE = 8'd10;
	localparam logic [CHAR_W-1:0]   BLANK_BYTE   = 8'd32;
	localparam logic [COLOR_W-1:0]  RESET_COLOR  = 8'h0F;
	localparam logic [NIBBLE_W-1:0] RESET_FG     = 4'd15;
	localparam logic [NIBBLE_W-1:0] RESET_BG     = 4'd0;

	// input kind codes
	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 4'd1;

	// command queue depth
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// classified operations
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUT,
		OP_NEWLINE,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [CHAR_W-1:0]       character;
		logic [ADDR_W-1:0]       index;
	} cmd_t;

	// head of the command queue as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	// back end sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_WRITE,
		ST_CLEAR,
		ST_SCROLL,
		ST_BLANK,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/tcw_front.sv -----
// tcw_front: accepts input transactions, classifies them into commands and
// holds them in a short queue for the back end. Depends on tcw_pkg.
module tcw_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [tcw_pkg::KIND_W-1:0]      kind,
	input  logic [tcw_pkg::CHAR_W-1:0]      character,
	input  logic [tcw_pkg::CELL_IDX_W-1:0]  cell_index,
	input  logic                            init_busy,
	output tcw_pkg::q_head_t                head,
	input  logic                            head_pop
);

	tcw_pkg::cmd_t                    q_q [tcw_pkg::QDEPTH];
	logic [tcw_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [tcw_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [tcw_pkg::QCNT_W-1:0]       count_q;
	tcw_pkg::cmd_t                    cmd_in;
	logic                             accept;
	logic                             take;

	// classify the incoming item
	always_comb begin
		cmd_in.character = character;
		cmd_in.index     = cell_index[tcw_pkg::ADDR_W-1:0];
		cmd_in.op        = tcw_pkg::OP_NOP;
		if (kind == tcw_pkg::KIND_PUT) begin
			cmd_in.op = (character == tcw_pkg::NEWLINE_BYTE) ? tcw_pkg::OP_NEWLINE
			                                                 : tcw_pkg::OP_PUT;
		end else if (kind == tcw_pkg::KIND_CLEAR) begin
			cmd_in.op = tcw_pkg::OP_CLEAR;
		end else if (kind == tcw_pkg::KIND_READ) begin
			// out-of-range reads behave as no-ops
			if (cell_index < tcw_pkg::CELL_IDX_W'(tcw_pkg::CELLS))
				cmd_in.op = tcw_pkg::OP_READ;
		end
	end

	// queue handshake; no items while the screen is cleared after reset
	assign full   = (count_q == tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH)) || init_busy;
	assign accept = push && !full;
	assign take   = head_pop && head.valid;

	assign head.valid = (count_q != '0);
	assign head.cmd   = q_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (accept)
			q_q[wr_ptr_q] <= cmd_in;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (take)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (accept && !take)
				count_q <= count_q + 1'b1;
			else if (take && !accept)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- rtl/tcw_back.sv -----
// tcw_back: executes console commands against the screen store, keeps the
// cursor and holds the result register. Depends on tcw_pkg.
module tcw_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tcw_pkg::q_head_t                head,
	output logic                            head_pop,
	output logic                            init_busy,
	input  logic [tcw_pkg::COLOR_W-1:0]     cur_color,
	output logic                            empty,
	input  logic                            pop,
	output logic [tcw_pkg::CHAR_W-1:0]      cell_character,
	output logic [tcw_pkg::COLOR_W-1:0]     cell_color,
	output logic [tcw_pkg::ROW_W-1:0]       cursor_row,
	output logic [tcw_pkg::COL_W-1:0]       cursor_column
);

	localparam int CELL_W = tcw_pkg::CHAR_W + tcw_pkg::COLOR_W;
	localparam logic [tcw_pkg::ADDR_W-1:0] COLS_A  = tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
	localparam logic [tcw_pkg::ADDR_W-1:0] LAST_A  = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
	localparam logic [tcw_pkg::ADDR_W-1:0] MOVED_A = tcw_pkg::ADDR_W'(tcw_pkg::MOVED);
	localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
	localparam logic [tcw_pkg::COL_W-1:0]  WIDTH_C  = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);

	// screen store: {color, character}
	logic [CELL_W-1:0]                 mem [tcw_pkg::CELLS];
	logic [CELL_W-1:0]                 rdata_q;

	tcw_pkg::state_t                   state_q, state_d;
	logic [tcw_pkg::ADDR_W-1:0]        addr_q;
	logic [tcw_pkg::ROW_W-1:0]         row_q;
	logic [tcw_pkg::COL_W-1:0]         col_q;
	logic [tcw_pkg::CHAR_W-1:0]        ch_q;
	logic                              wr_after_q;
	logic                              copy_v_q;
	logic [tcw_pkg::ADDR_W-1:0]        copy_addr_q;
	logic [tcw_pkg::CHAR_W-1:0]        res_char_q;
	logic [tcw_pkg::COLOR_W-1:0]       res_color_q;
	logic                              out_valid_q;
	logic [tcw_pkg::CHAR_W-1:0]        out_char_q;
	logic [tcw_pkg::COLOR_W-1:0]       out_color_q;
	logic [tcw_pkg::ROW_W-1:0]         out_row_q;
	logic [tcw_pkg::COL_W-1:0]         out_col_q;

	logic                              mem_we;
	logic [tcw_pkg::ADDR_W-1:0]        mem_waddr;
	logic [CELL_W-1:0]                 mem_wdata;
	logic                              mem_re;
	logic [tcw_pkg::ADDR_W-1:0]        mem_raddr;

	logic                              last_cell;
	logic                              scroll_end;
	logic                              at_bottom;
	logic                              wrap;
	logic                              out_free;
	logic                              dispatch;
	logic [tcw_pkg::ADDR_W-1:0]        cur_addr;

	// status terms
	assign last_cell  = (addr_q == LAST_A);
	assign scroll_end = (addr_q == MOVED_A);
	assign at_bottom  = (row_q == LAST_ROW);
	assign wrap       = (col_q >= WIDTH_C);
	assign out_free   = !out_valid_q || pop;
	assign dispatch   = (state_q == tcw_pkg::ST_IDLE) && head.valid;
	assign cur_addr   = tcw_pkg::ADDR_W'(row_q) * COLS_A + tcw_pkg::ADDR_W'(col_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT:   if (last_cell) state_d = tcw_pkg::ST_IDLE;
			tcw_pkg::ST_IDLE: begin
				if (head.valid) begin
					unique case (head.cmd.op)
						tcw_pkg::OP_READ:    state_d = tcw_pkg::ST_READ;
						tcw_pkg::OP_CLEAR:   state_d = tcw_pkg::ST_CLEAR;
						tcw_pkg::OP_NEWLINE: state_d = at_bottom ? tcw_pkg::ST_SCROLL
						                                         : tcw_pkg::ST_DONE;
						tcw_pkg::OP_PUT:     state_d = (wrap && at_bottom) ? tcw_pkg::ST_SCROLL
						                                                   : tcw_pkg::ST_WRITE;
						default:             state_d = tcw_pkg::ST_DONE;
					endcase
				end
			end
			tcw_pkg::ST_READ:   state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_WRITE:  state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_CLEAR:  if (last_cell) state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_SCROLL: if (scroll_end) state_d = tcw_pkg::ST_BLANK;
			tcw_pkg::ST_BLANK: begin
				if (last_cell)
					state_d = wr_after_q ? tcw_pkg::ST_WRITE : tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_DONE:   if (out_free) state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// memory control and handshake outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = {cur_color, tcw_pkg::BLANK_BYTE};
		mem_re    = 1'b0;
		mem_raddr = head.cmd.index;
		head_pop  = dispatch;
		init_busy = (state_q == tcw_pkg::ST_INIT);
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::BLANK_BYTE};
			end
			tcw_pkg::ST_IDLE: begin
				mem_re = head.valid && (head.cmd.op == tcw_pkg::OP_READ);
			end
			tcw_pkg::ST_WRITE: begin
				mem_we    = 1'b1;
				mem_waddr = cur_addr;
				mem_wdata = {cur_color, ch_q};
			end
			tcw_pkg::ST_CLEAR, tcw_pkg::ST_BLANK: begin
				mem_we = 1'b1;
			end
			tcw_pkg::ST_SCROLL: begin
				// read one row ahead, write the cell read the cycle before
				mem_re    = !scroll_end;
				mem_raddr = addr_q + COLS_A;
				mem_we    = copy_v_q;
				mem_waddr = copy_addr_q;
				mem_wdata = rdata_q;
			end
			tcw_pkg::ST_READ, tcw_pkg::ST_DONE: begin
			end
		endcase
	end

	// screen store
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_raddr];
	end

	// pending character and result data
	always_ff @(posedge clk) begin
		copy_addr_q <= addr_q;
		if (dispatch) begin
			ch_q        <= head.cmd.character;
			res_char_q  <= '0;
			res_color_q <= '0;
		end
		if (state_q == tcw_pkg::ST_READ) begin
			res_char_q  <= rdata_q[tcw_pkg::CHAR_W-1:0];
			res_color_q <= rdata_q[CELL_W-1:tcw_pkg::CHAR_W];
		end
		if (state_q == tcw_pkg::ST_DONE && out_free) begin
			out_char_q  <= res_char_q;
			out_color_q <= res_color_q;
			out_row_q   <= row_q;
			out_col_q   <= col_q;
		end
	end

	// sequencer, sweep counter and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_INIT;
			addr_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			wr_after_q  <= 1'b0;
			copy_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			copy_v_q <= (state_q == tcw_pkg::ST_SCROLL) && !scroll_end;

			// sweep address
			if (dispatch)
				addr_q <= '0;
			else if (state_q == tcw_pkg::ST_INIT || state_q == tcw_pkg::ST_CLEAR ||
			         state_q == tcw_pkg::ST_BLANK ||
			         (state_q == tcw_pkg::ST_SCROLL && !scroll_end))
				addr_q <= addr_q + 1'b1;

			// cursor moves at dispatch for line breaks, after a write for advance
			if (dispatch) begin
				wr_after_q <= (head.cmd.op == tcw_pkg::OP_PUT);
				if (head.cmd.op == tcw_pkg::OP_NEWLINE ||
				    (head.cmd.op == tcw_pkg::OP_PUT && wrap)) begin
					col_q <= '0;
					if (!at_bottom)
						row_q <= row_q + 1'b1;
				end
			end
			if (state_q == tcw_pkg::ST_WRITE)
				col_q <= col_q + 1'b1;

			// result register
			if (state_q == tcw_pkg::ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	assign empty          = !out_valid_q;
	assign cell_character = out_char_q;
	assign cell_color     = out_color_q;
	assign cursor_row     = out_row_q;
	assign cursor_column  = out_col_q;

endmodule

// ----- rtl/text_console_writer.sv -----
// text_console_writer: top level of the character-cell text console.
// Holds the color registers; instantiates tcw_front and tcw_back; uses tcw_pkg.
//
// Usage:
//   Input queue: an item (kind, character, cell_index) is taken on a clock
//   edge with push high and full low. Result queue: while empty is low the
//   oldest result sits on cell_character, cell_color, cursor_row and
//   cursor_column; pop takes it. Every item gives exactly one result.
//   Colors are written through cfg_valid/cfg_ready with cfg_index 0 for the
//   foreground and 1 for the background nibble; cfg_ready is always high.
//   The sequencer over the screen store handles one item at a time: a
//   printed byte is written to its cell (after a scroll when its wrap
//   is on the bottom row), a read fetches one cell, a clear blanks every
//   cell, and a newline on the bottom row scrolls (one cell copied per
//   cycle, then the bottom row blanked). Items reach the sequencer
//   through a two-entry command queue.
//   After reset the store is filled with blanks, all ROWS*COLUMNS cells
//   (2000 at 80x25), while full stays high; color writes are taken meanwhile.
//   When pop stays low, one result waits, one item can be in work and two
//   more wait in the queue before full rises.
module text_console_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [tcw_pkg::KIND_W-1:0]        kind,
	input  logic [tcw_pkg::CHAR_W-1:0]        character,
	input  logic [tcw_pkg::CELL_IDX_W-1:0]    cell_index,
	output logic                              empty,
	input  logic                              pop,
	output logic [tcw_pkg::CHAR_W-1:0]        cell_character,
	output logic [tcw_pkg::COLOR_W-1:0]       cell_color,
	output logic [tcw_pkg::ROW_W-1:0]         cursor_row,
	output logic [tcw_pkg::COL_W-1:0]         cursor_column,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::NIBBLE_W-1:0]      cfg_data
);

	logic [tcw_pkg::NIBBLE_W-1:0] fg_q;
	logic [tcw_pkg::NIBBLE_W-1:0] bg_q;
	tcw_pkg::q_head_t             head;
	logic                         head_pop;
	logic                         init_busy;

	// color registers; unknown indexes are ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::RESET_FG;
			bg_q <= tcw_pkg::RESET_BG;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tcw_pkg::REG_FOREGROUND)
				fg_q <= cfg_data;
			else if (cfg_index == tcw_pkg::REG_BACKGROUND)
				bg_q <= cfg_data;
		end
	end

	tcw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.character  (character),
		.cell_index (cell_index),
		.init_busy  (init_busy),
		.head       (head),
		.head_pop   (head_pop)
	);

	tcw_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.head_pop       (head_pop),
		.init_busy      (init_busy),
		.cur_color      ({bg_q, fg_q}),
		.empty          (empty),
		.pop            (pop),
		.cell_character (cell_character),
		.cell_color     (cell_color),
		.cursor_row     (cursor_row),
		.cursor_column  (cursor_column)
	);

endmodule

// ----- tb/text_console_writer_tb.sv -----
// text_console_writer_tb: self-checking testbench for the text console writer.
// Drives put, clear and read transactions and checks each result against a
// shadow copy of the screen store and cursor; depends on tcw_pkg and the RTL.
module text_console_writer_tb;

	// kind code that the block must ignore
	localparam logic [tcw_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 12000;
	localparam int MAX_REPORTS = 10;
	localparam int TAIL_CYCLES = 20;
	localparam int RESET_CYCLES = 6;

	// one result transaction as seen on the output ports
	typedef struct packed {
		logic [tcw_pkg::CHAR_W-1:0]  character;
		logic [tcw_pkg::COLOR_W-1:0] color;
		logic [tcw_pkg::ROW_W-1:0]   row;
		logic [tcw_pkg::COL_W-1:0]   column;
	} cell_view_t;

	logic                           clk;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	logic [tcw_pkg::KIND_W-1:0]     kind;
	logic [tcw_pkg::CHAR_W-1:0]     character;
	logic [tcw_pkg::CELL_IDX_W-1:0] cell_index;
	logic                           empty;
	logic                           pop;
	logic [tcw_pkg::CHAR_W-1:0]     cell_character;
	logic [tcw_pkg::COLOR_W-1:0]    cell_color;
	logic [tcw_pkg::ROW_W-1:0]      cursor_row;
	logic [tcw_pkg::COL_W-1:0]      cursor_column;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tcw_pkg::NIBBLE_W-1:0]   cfg_data;

	// shadow console state
	logic [tcw_pkg::CHAR_W-1:0]   shadow_char  [tcw_pkg::CELLS];
	logic [tcw_pkg::COLOR_W-1:0]  shadow_color [tcw_pkg::CELLS];
	int                           shadow_row;
	int                           shadow_col;
	logic [tcw_pkg::NIBBLE_W-1:0] shadow_fg;
	logic [tcw_pkg::NIBBLE_W-1:0] shadow_bg;

	cell_view_t expected_views[$];

	int errors;
	int items_sent;
	int results_seen;
	int read_count;
	int clear_count;
	int scroll_count;
	int wrap_count;
	int cfg_writes;
	int quiet_cycles;
	int rx_stall;
	bit tx_idle_mode;
	bit rx_idle_mode;

	text_console_writer uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.character      (character),
		.cell_index     (cell_index),
		.empty          (empty),
		.pop            (pop),
		.cell_character (cell_character),
		.cell_color     (cell_color),
		.cursor_row     (cursor_row),
		.cursor_column  (cursor_column),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// sized views of integer values
	function automatic logic [tcw_pkg::CELL_IDX_W-1:0] to_idx(int v);
		return tcw_pkg::CELL_IDX_W'(v);
	endfunction

	function automatic logic [tcw_pkg::CHAR_W-1:0] to_byte(int v);
		return tcw_pkg::CHAR_W'(v);
	endfunction

	function automatic logic [tcw_pkg::NIBBLE_W-1:0] to_nibble(int v);
		return tcw_pkg::NIBBLE_W'(v);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [tcw_pkg::COLOR_W-1:0] shadow_attr();
		return {shadow_bg, shadow_fg};
	endfunction

	function automatic void shadow_blank_row(int r);
		logic [tcw_pkg::COLOR_W-1:0] attr;
		attr = shadow_attr();
		for (int c = 0; c < tcw_pkg::COLUMNS; c++) begin
			shadow_char[r * tcw_pkg::COLUMNS + c]  = tcw_pkg::BLANK_BYTE;
			shadow_color[r * tcw_pkg::COLUMNS + c] = attr;
		end
	endfunction

	// column to 0, then next row or scroll up one row
	function automatic void shadow_newline();
		shadow_col = 0;
		if (shadow_row + 1 < tcw_pkg::ROWS) begin
			shadow_row++;
		end else begin
			for (int i = 0; i < tcw_pkg::MOVED; i++) begin
				shadow_char[i]  = shadow_char[i + tcw_pkg::COLUMNS];
				shadow_color[i] = shadow_color[i + tcw_pkg::COLUMNS];
			end
			shadow_blank_row(tcw_pkg::ROWS - 1);
			scroll_count++;
		end
	endfunction

	// applies one input transaction to the shadow and returns the expected result
	function automatic cell_view_t console_step(logic [tcw_pkg::KIND_W-1:0] k,
			logic [tcw_pkg::CHAR_W-1:0] ch, logic [tcw_pkg::CELL_IDX_W-1:0] idx);
		cell_view_t v;
		int at;
		v = '0;
		case (k)
			tcw_pkg::KIND_PUT: begin
				if (ch == tcw_pkg::NEWLINE_BYTE) begin
					shadow_newline();
				end else begin
					// pending wrap resolves before the byte lands
					if (shadow_col >= tcw_pkg::COLUMNS) begin
						shadow_newline();
						wrap_count++;
					end
					at = shadow_row * tcw_pkg::COLUMNS + shadow_col;
					shadow_char[at]  = ch;
					shadow_color[at] = shadow_attr();
					shadow_col++;
				end
			end
			tcw_pkg::KIND_CLEAR: begin
				for (int r = 0; r < tcw_pkg::ROWS; r++)
					shadow_blank_row(r);
				clear_count++;
			end
			tcw_pkg::KIND_READ: begin
				if (idx < tcw_pkg::CELLS) begin
					v.character = shadow_char[idx];
					v.color     = shadow_color[idx];
				end
				read_count++;
			end
			default: ;
		endcase
		v.row    = shadow_row[tcw_pkg::ROW_W-1:0];
		v.column = shadow_col[tcw_pkg::COL_W-1:0];
		return v;
	endfunction

	// result side: random pop stalls
	always @(posedge clk) begin
		if (rx_stall > 0) begin
			pop      <= 1'b0;
			rx_stall <= rx_stall - 1;
		end else begin
			pop <= 1'b1;
			if (rx_idle_mode)
				rx_stall <= idle_length();
		end
	end

	// result checker
	always @(posedge clk) begin
		cell_view_t want;
		cell_view_t got;
		if (arst_n && pop && !empty) begin
			got.character = cell_character;
			got.color     = cell_color;
			got.row       = cursor_row;
			got.column    = cursor_column;
			results_seen++;
			if (expected_views.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: char %0d color %02h row %0d col %0d",
						got.character, got.color, got.row, got.column);
			end else begin
				want = expected_views.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("result %0d mismatch: expected char %0d color %02h row %0d col %0d",
							results_seen, want.character, want.color, want.row, want.column);
						$display("  got char %0d color %02h row %0d col %0d",
							got.character, got.color, got.row, got.column);
					end
				end
			end
		end
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				quiet_cycles, expected_views.size());
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// sends one input transaction and records its expected result
	task automatic send_item(logic [tcw_pkg::KIND_W-1:0] k, logic [tcw_pkg::CHAR_W-1:0] ch,
			logic [tcw_pkg::CELL_IDX_W-1:0] idx);
		int gap;
		gap = tx_idle_mode ? idle_length() : 0;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push       <= 1'b1;
		kind       <= k;
		character  <= ch;
		cell_index <= idx;
		@(posedge clk);
		while (full) @(posedge clk);
		expected_views.push_back(console_step(k, ch, idx));
		items_sent++;
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain();
		if (push)
			push <= 1'b0;
		while (expected_views.size() != 0) @(posedge clk);
	endtask

	// color registers change only while the block is idle
	task automatic set_colors(logic [tcw_pkg::NIBBLE_W-1:0] fg,
			logic [tcw_pkg::NIBBLE_W-1:0] bg);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= tcw_pkg::REG_FOREGROUND;
		cfg_data  <= fg;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_fg = fg;
		cfg_index <= tcw_pkg::REG_BACKGROUND;
		cfg_data  <= bg;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		shadow_bg = bg;
		cfg_writes += 2;
	endtask

	task automatic apply_reset();
		for (int i = 0; i < tcw_pkg::CELLS; i++) begin
			shadow_char[i]  = tcw_pkg::BLANK_BYTE;
			shadow_color[i] = tcw_pkg::RESET_COLOR;
		end
		shadow_row = 0;
		shadow_col = 0;
		shadow_fg  = tcw_pkg::RESET_FG;
		shadow_bg  = tcw_pkg::RESET_BG;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		// the block blanks its store before taking items
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// store contents after reset, out-of-range reads, ignored kind
	task automatic test_reset_state();
		send_item(tcw_pkg::KIND_READ, 8'd0, 11'd0);
		send_item(tcw_pkg::KIND_READ, 8'd0, to_idx(tcw_pkg::CELLS - 1));
		send_item(tcw_pkg::KIND_READ, 8'd255, to_idx(tcw_pkg::CELLS));
		send_item(tcw_pkg::KIND_READ, 8'd0, 11'h7FF);
		send_item(KIND_UNUSED, 8'hFF, 11'h7FF);
	endtask

	// byte extremes, newline, read back
	task automatic test_put_bytes();
		send_item(tcw_pkg::KIND_PUT, 8'd0, 11'd0);
		send_item(tcw_pkg::KIND_PUT, 8'd255, 11'h7FF);
		send_item(tcw_pkg::KIND_PUT, "A", 11'd0);
		send_item(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_BYTE, 11'd0);
		send_item(tcw_pkg::KIND_PUT, "B", 11'd0);
		for (int i = 0; i < 3; i++)
			send_item(tcw_pkg::KIND_READ, 8'd0, to_idx(i));
		send_item(tcw_pkg::KIND_READ, 8'd0, to_idx(tcw_pkg::COLUMNS));
		send_item(tcw_pkg::KIND_READ, 8'd0, to_idx(tcw_pkg::COLUMNS + 1));
	endtask

	// color extremes, color change affects new cells only, clear
	task automatic test_color_extremes();
		set_colors(4'd0, 4'd0);
		send_item(tcw_pkg::KIND_PUT, "x", 11'd0);
		set_colors(4'd15, 4'd15);
		send_item(tcw_pkg::KIND_PUT, "y", 11'd0);
		send_item(tcw_pkg::KIND_READ, 8'd0, to_idx(tcw_pkg::COLUMNS + 1));
		send_item(tcw_pkg::KIND_READ, 8'd0, to_idx(tcw_pkg::COLUMNS + 2));
		set_colors(4'd0, 4'd15);
		send_item(tcw_pkg::KIND_CLEAR, 8'd0, 11'd0);
		send_item(tcw_pkg::KIND_READ, 8'd0, 11'd0);
		send_item(tcw_pkg::KIND_READ, 8'd0, to_idx(tcw_pkg::CELLS - 1));
		set_colors(4'd15, 4'd0);
	endtask

	// lines of text with reads near the cursor; long lines wrap, bottom row scrolls
	task automatic test_text_stream(int count);
		int line_left;
		int r;
		int col;
		logic [tcw_pkg::CHAR_W-1:0] ch;
		line_left = $urandom_range(0, 120);
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				if (line_left == 0) begin
					send_item(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_BYTE,
						to_idx($urandom_range(0, 2047)));
					line_left = $urandom_range(0, 120);
				end else begin
					ch = ($urandom_range(0, 99) < 85) ? to_byte($urandom_range(32, 126))
						: to_byte($urandom_range(0, 255));
					if (ch == tcw_pkg::NEWLINE_BYTE)
						ch = tcw_pkg::BLANK_BYTE;
					send_item(tcw_pkg::KIND_PUT, ch, to_idx($urandom_range(0, 2047)));
					line_left--;
				end
			end else if (r < 90) begin
				// current or previous row of the cursor
				col = $urandom_range(0, tcw_pkg::COLUMNS - 1);
				if (shadow_row > 0 && $urandom_range(0, 1))
					send_item(tcw_pkg::KIND_READ, to_byte($urandom_range(0, 255)),
						to_idx((shadow_row - 1) * tcw_pkg::COLUMNS + col));
				else
					send_item(tcw_pkg::KIND_READ, to_byte($urandom_range(0, 255)),
						to_idx(shadow_row * tcw_pkg::COLUMNS + col));
			end else if (r < 99) begin
				send_item(tcw_pkg::KIND_READ, to_byte($urandom_range(0, 255)),
					to_idx($urandom_range(0, tcw_pkg::CELLS - 1)));
			end else begin
				send_item(tcw_pkg::KIND_CLEAR, to_byte($urandom_range(0, 255)),
					to_idx($urandom_range(0, 2047)));
			end
		end
	endtask

	// back-to-back bursts, sender holds until all results are back
	task automatic test_pressure_drain();
		tx_idle_mode = 1'b0;
		rx_idle_mode = 1'b0;
		for (int b = 0; b < 4; b++) begin
			test_text_stream(25);
			drain();
		end
		tx_idle_mode = 1'b1;
		rx_idle_mode = 1'b1;
	endtask

	// unstructured items: all kinds, any byte, any index
	task automatic test_noise(int count);
		int r;
		logic [tcw_pkg::KIND_W-1:0] k;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				k = tcw_pkg::KIND_CLEAR;
			else if (r < 10)
				k = KIND_UNUSED;
			else if (r < 55)
				k = tcw_pkg::KIND_PUT;
			else
				k = tcw_pkg::KIND_READ;
			send_item(k, to_byte($urandom_range(0, 255)), to_idx($urandom_range(0, 2047)));
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		push         <= 1'b0;
		pop          <= 1'b0;
		kind         <= tcw_pkg::KIND_PUT;
		character    <= '0;
		cell_index   <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= tcw_pkg::REG_FOREGROUND;
		cfg_data     <= '0;
		tx_idle_mode = 1'b1;
		rx_idle_mode = 1'b1;

		apply_reset();
		test_reset_state();
		test_put_bytes();
		test_color_extremes();

		// text chunks under several color settings; first chunk without idling
		tx_idle_mode = 1'b0;
		rx_idle_mode = 1'b0;
		test_text_stream(200);
		tx_idle_mode = 1'b1;
		rx_idle_mode = 1'b1;
		set_colors(4'd15, 4'd0);
		test_text_stream(200);
		set_colors(4'd0, 4'd15);
		test_text_stream(200);
		for (int c = 0; c < 3; c++) begin
			set_colors(to_nibble($urandom_range(0, 15)), to_nibble($urandom_range(0, 15)));
			test_text_stream(200);
		end
		test_pressure_drain();
		set_colors(4'd0, 4'd0);
		test_noise(200);
		set_colors(to_nibble($urandom_range(0, 15)), to_nibble($urandom_range(0, 15)));
		test_noise(220);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d items and %0d results: %0d reads, %0d clears, %0d scrolls",
			items_sent, results_seen, read_count, clear_count, scroll_count);
		$display("%0d wraps, %0d color register writes, %0d mismatches",
			wrap_count, cfg_writes, errors);
		if (errors == 0 && expected_views.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
tb/text_console_writer_tb.sv
